// ----- sv/dqmm_pkg.sv -----
`timescale 1ns / 1ps
package dqmm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_MAX        = 3'd4,
        OP_MIN        = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // item accepted this cycle
        logic scan;   // query scan in progress
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic query_go;  // offered item is a query on a non-empty queue
        logic scan_end;  // last entry of the scan is being compared
    } t_stat;

endpackage

// ----- sv/deque_with_min_max_query.sv -----
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values with max/min query.
//
// Input channel: an item (i_opcode, i_value_in) is taken at a rising edge
// where i_start is high and o_busy is low. Opcodes: push front, push back,
// pop front, pop back, max, min; the two unused codes are ignored with ok.
// Result channel: every item gives one result (o_status, o_found_value,
// o_count_after), shown for one cycle while o_valid is high. The receiver
// cannot stall; it must take the result in that cycle.
//
// Timing: pushes, pops, ignored codes and queries on an empty queue give
// their result in the cycle after acceptance, and o_busy stays low, so one
// such item can be taken every cycle. A query keeps o_busy high while the
// single read port of the entry RAM reads the held entries, one entry per
// cycle, and through its registered read; the result appears in the first
// cycle after o_busy falls, in which a new item may already be taken.
//
// Reset (i_rst_n low, synchronous) empties the queue and drops any scan in
// progress; the stored values themselves are not cleared.
module deque_with_min_max_query
    import dqmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [OP_W-1:0]             i_opcode,
    input  logic signed [DATA_W-1:0]    i_value_in,
    output logic                        o_valid,
    output logic [ST_W-1:0]             o_status,
    output logic signed [DATA_W-1:0]    o_found_value,
    output logic [$clog2(DEPTH+1)-1:0]  o_count_after
);

    t_cmd  cmd;
    t_stat stat;

    // sequence items: accept, then hold busy through a query scan
    dqmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // front pointer, count, entry RAM, scan compare and result registers
    dqmm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_value_in    (i_value_in),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_count_after (o_count_after)
    );

endmodule

// ----- sv/dqmm_ram.sv -----
`timescale 1ns / 1ps
module dqmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dqmm_ctrl.sv -----
`timescale 1ns / 1ps
module dqmm_ctrl
    import dqmm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state    = r_state;
        o_cmd.exec = 1'b0;
        o_cmd.scan = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.query_go) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state == S_SCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

    // no item is taken while a scan is running
    a_no_exec_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_cmd.exec)
        else $error("item accepted during scan");

    // a scan that ends releases the block on the next cycle
    a_scan_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_stat.scan_end) |=> !r_busy)
        else $error("busy held after scan end");

    // a query on a non-empty queue raises busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && i_stat.query_go) |=> r_busy)
        else $error("query did not start scan");

endmodule

// ----- sv/dqmm_dp.sv -----
`timescale 1ns / 1ps
module dqmm_dp
    import dqmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [OP_W-1:0]             i_opcode,
    input  logic signed [DATA_W-1:0]    i_value_in,
    output t_stat                       o_stat,
    output logic                        o_valid,
    output logic [ST_W-1:0]             o_status,
    output logic signed [DATA_W-1:0]    o_found_value,
    output logic [$clog2(DEPTH+1)-1:0]  o_count_after
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op                      op;
    logic                     is_query;
    logic                     empty;
    logic                     full;
    logic [AW:0]              back_sum;
    logic [AW-1:0]            back_slot;
    logic [AW-1:0]            n_front;
    logic [CW-1:0]            n_count;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    t_status                  ex_status;
    logic signed [DATA_W-1:0] rd_data;
    logic                     better;
    logic                     take;
    logic signed [DATA_W-1:0] pick;

    logic [AW-1:0]            r_front;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_left;
    logic                     r_rd_vld;
    logic [AW-1:0]            r_slot;
    logic                     r_want_max;
    logic                     r_have;
    logic signed [DATA_W-1:0] r_best;
    logic                     r_valid;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_found;
    logic [CW-1:0]            r_cnt_out;

    assign op       = t_op'(i_opcode);
    assign is_query = (op == OP_MAX) || (op == OP_MIN);
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(DEPTH));

    // slot just past the back; count is below DEPTH whenever this is used
    assign back_sum  = {1'b0, r_front} + (AW+1)'(r_count);
    assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                    : AW'(back_sum);

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = back_slot;
        ex_status = ST_OK;
        unique case (op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    n_front   = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
                    ram_we    = i_cmd.exec;
                    ram_waddr = n_front;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    ram_we  = i_cmd.exec;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else begin
                    n_front = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_MAX, OP_MIN: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end
            end
            default: ex_status = ST_OK;
        endcase
    end

    dqmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value_in),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    assign better = r_want_max ? (rd_data > r_best) : (rd_data < r_best);
    assign take   = !r_have || better;
    assign pick   = take ? rd_data : r_best;

    assign o_stat.query_go = is_query && !empty;
    assign o_stat.scan_end = r_rd_vld && (r_left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (i_cmd.exec && !o_stat.query_go) || (i_cmd.scan && o_stat.scan_end);
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
                if (o_stat.query_go) begin
                    r_left <= r_count;
                end
            end
            if (i_cmd.scan) begin
                r_rd_vld <= (r_left != '0);
                if (r_left != '0) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    // scan pointer, running extreme and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (o_stat.query_go) begin
                r_slot     <= r_front;
                r_want_max <= (op == OP_MAX);
                r_have     <= 1'b0;
            end else begin
                r_status  <= ex_status;
                r_found   <= '0;
                r_cnt_out <= n_count;
            end
        end
        if (i_cmd.scan) begin
            if (r_left != '0) begin
                r_slot <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (r_rd_vld) begin
                r_best <= pick;
                r_have <= 1'b1;
            end
            if (o_stat.scan_end) begin
                r_status  <= ST_OK;
                r_found   <= pick;
                r_cnt_out <= r_count;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_count_after = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_count)
        else $error("scan length above entry count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && ram_we) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the queue");

endmodule
